// ===== hdl/evf_pkg.sv =====
package evf_pkg;
  localparam int TILE_LAST = 3600;
  localparam int LINE_DEPTH = TILE_LAST + 1;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = 12;
  localparam int DW = 16;
  localparam logic CFG_MIN_ELEV = 1'b0;
  localparam logic CFG_LAST_IDX = 1'b1;

  // Reciprocals for exact division of a 19-bit magnitude by 3, 5 and 7.
  localparam logic [19:0] RECIP3 = 20'd699051;
  localparam logic [19:0] RECIP5 = 20'd838861;
  localparam logic [19:0] RECIP7 = 20'd599187;

  typedef struct packed {
    logic signed [DW-1:0] elevation;
    logic [CW-1:0]        row;
    logic [CW-1:0]        col;
    logic                 was_void;
  } res_t;

  typedef struct packed {
    logic [DW-1:0] s;
    logic [CW-1:0] r;
    logic [CW-1:0] c;
  } job_t;
endpackage

// ===== hdl/evf_if.sv =====
interface evf_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample;
  logic tile_start;
  modport source(output valid, sample, tile_start, input ready);
  modport sink(input valid, sample, tile_start, output ready);
endinterface

interface evf_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] elevation;
  logic [11:0] row;
  logic [11:0] col;
  logic was_void;
  modport source(output valid, elevation, row, col, was_void, input ready);
  modport sink(input valid, elevation, row, col, was_void, output ready);
endinterface

// ===== hdl/evf_ram.sv =====
module evf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/evf_front.sv =====
module evf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_sample,
  input  logic                in_tile_start,
  input  logic [11:0]         last,
  output logic                q_valid,
  input  logic                q_ready,
  output evf_pkg::job_t       q_job
);
  import evf_pkg::*;
  logic [CW-1:0] row_r, col_r, r, c;
  logic [1:0] cnt_r;
  job_t buf_r [2];
  logic wp_r, rp_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = buf_r[rp_r];

  always_comb begin
    r = in_tile_start ? last : row_r;
    c = in_tile_start ? last : col_r;
    if (r > CW'(TILE_LAST)) r = CW'(TILE_LAST);
    if (c > CW'(TILE_LAST)) c = CW'(TILE_LAST);
  end

  wire push = in_valid && in_ready;
  wire pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) begin
        buf_r[wp_r] <= '{s: in_sample, r: r, c: c};
        wp_r <= ~wp_r;
        if (c == '0) begin
          col_r <= last;
          row_r <= (r == '0) ? last : r - CW'(1);
        end else begin
          col_r <= c - CW'(1);
          row_r <= r;
        end
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/evf_back.sv =====
module evf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  evf_pkg::job_t       q_job,
  input  logic signed [15:0]  min_elev,
  input  logic [11:0]         last,
  output logic                o_valid,
  input  logic                o_ready,
  output evf_pkg::res_t       o_res
);
  import evf_pkg::*;
  typedef enum logic [2:0] {S_READ = 3'b001, S_SUM = 3'b010, S_DIV = 3'b100} st_t;
  st_t st_r;
  job_t job_r;
  logic [DW-1:0] w_r [3][3];
  logic [DW-1:0] fl_q, rl_q;
  logic fl_we;
  logic [AW-1:0] fl_wa;
  logic [DW-1:0] fl_wd;
  logic signed [19:0] sum_r;
  logic [3:0] n_r;
  res_t res_r;
  logic ov_r;

  logic [CW:0] y, x;
  logic emit, isv, up, down, right;
  logic signed [DW-1:0] ctr, v, nb [8], res;
  logic [7:0] use_nb, sel;
  logic signed [19:0] term [8];
  logic signed [19:0] sum;
  logic [3:0] n;
  logic signed [20:0] num, avg;
  logic [19:0] mag;
  logic [18:0] half, quo;
  logic [38:0] prod;

  evf_ram #(.WIDTH(DW), .DEPTH(LINE_DEPTH)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
    .raddr(AW'(q_job.c)), .rdata(fl_q));
  evf_ram #(.WIDTH(DW), .DEPTH(LINE_DEPTH)) u_rl (
    .clk(clk), .we(q_valid && q_ready), .waddr(AW'(q_job.c)), .wdata(q_job.s),
    .raddr(AW'(q_job.c)), .rdata(rl_q));

  assign q_ready = (st_r == S_READ) && (!ov_r || o_ready);
  assign o_valid = ov_r;
  assign o_res = res_r;

  // The neighbour sum is formed from the window before its shift, the
  // average from the registered sum once the window has moved on.
  always_comb begin
    y = {1'b0, job_r.r} + (CW+1)'(1);
    x = {1'b0, job_r.c} + (CW+1)'(1);
    emit = (y <= {1'b0, last}) && (x <= {1'b0, last});
    up = y >= (CW+1)'(2);
    down = y + (CW+1)'(1) <= {1'b0, last};
    right = x + (CW+1)'(2) <= {1'b0, last};
    ctr = w_r[1][2];
    nb[0] = w_r[2][2]; use_nb[0] = up;
    nb[1] = w_r[0][2]; use_nb[1] = down;
    nb[2] = w_r[2][1]; use_nb[2] = up && right;
    nb[3] = w_r[1][1]; use_nb[3] = right;
    nb[4] = w_r[0][1]; use_nb[4] = right && down;
    nb[5] = job_r.s;   use_nb[5] = up;
    nb[6] = rl_q;      use_nb[6] = 1'b1;
    nb[7] = fl_q;      use_nb[7] = down;
    for (int i = 0; i < 8; i++) begin
      sel[i] = use_nb[i] && (nb[i] > ctr);
      term[i] = sel[i] ? 20'(nb[i]) : 20'sd0;
    end
    sum = ((term[0] + term[1]) + (term[2] + term[3])) +
          ((term[4] + term[5]) + (term[6] + term[7]));
    n = 4'($countones(sel));

    num = $signed({sum_r, 1'b0} + {17'd0, n_r});
    mag = num[20] ? 20'(-num) : num[19:0];
    half = 19'(mag >> 1);
    prod = '0;
    case (n_r)
      4'd1: quo = half;
      4'd2: quo = half >> 1;
      4'd3: begin
        prod = 39'(half) * 39'(RECIP3);
        quo = 19'(prod >> 21);
      end
      4'd4: quo = half >> 2;
      4'd5: begin
        prod = 39'(half) * 39'(RECIP5);
        quo = 19'(prod >> 22);
      end
      4'd6: begin
        prod = 39'(half[18:1]) * 39'(RECIP3);
        quo = 19'(prod >> 21);
      end
      4'd7: begin
        prod = 39'(half) * 39'(RECIP7);
        quo = 19'(prod >> 22);
      end
      4'd8: quo = half >> 3;
      default: quo = '0;
    endcase
    avg = num[20] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    v = w_r[1][1];
    isv = v < min_elev;
    res = v;
    if (isv) begin
      res = min_elev;
      if (n_r != 4'd0 && avg > 21'(min_elev)) res = avg[DW-1:0];
    end

    fl_we = 1'b0;
    fl_wa = '0;
    fl_wd = rl_q;
    if (st_r == S_SUM && job_r.c == '0) begin
      fl_we = 1'b1;
    end else if (st_r == S_DIV && emit) begin
      fl_we = 1'b1;
      fl_wa = AW'(x);
      fl_wd = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_READ;
      ov_r <= 1'b0;
      sum_r <= '0;
      n_r <= '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) w_r[i][j] <= '0;
    end else begin
      if (st_r == S_DIV && emit) ov_r <= 1'b1;
      else if (o_valid && o_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_READ: if (q_valid && q_ready) begin
          job_r <= q_job;
          st_r <= S_SUM;
        end
        S_SUM: begin
          sum_r <= sum;
          n_r <= n;
          for (int i = 0; i < 3; i++) begin
            w_r[i][0] <= w_r[i][1];
            w_r[i][1] <= w_r[i][2];
          end
          w_r[0][2] <= fl_q;
          w_r[1][2] <= rl_q;
          w_r[2][2] <= job_r.s;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (emit) begin
            if (isv) w_r[1][1] <= res;
            res_r <= '{elevation: res, row: y[CW-1:0], col: x[CW-1:0], was_void: isv};
          end
          st_r <= S_READ;
        end
        default: st_r <= S_READ;
      endcase
    end
  end
endmodule

// ===== hdl/elevation_void_fill.sv =====
// An accepted item waits in the front queue; the back end reads the line stores
// in S_READ, forms the neighbour sum in S_SUM and averages with fill feedback in
// S_DIV, which registers the result. It takes no new item before the last one is
// through those states; a waiting result holds it.
// Reset: synchronous, active low; counters, queue and window clear, line
// stores hold undefined contents until written.
module elevation_void_fill (
  input  logic        clk,
  input  logic        rst_n,
  evf_in_if.sink      in_ch,
  evf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import evf_pkg::*;
  logic signed [15:0] min_r;
  logic [11:0] last_r;
  logic q_valid, q_ready;
  job_t q_job;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      last_r <= 12'(TILE_LAST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_ELEV: min_r <= cfg_data;
        CFG_LAST_IDX: last_r <= (cfg_data[11:0] < 12'd2) ? 12'd2 :
          (cfg_data[11:0] > 12'(TILE_LAST)) ? 12'(TILE_LAST) : cfg_data[11:0];
        default: ;
      endcase
    end
  end

  evf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_sample(in_ch.sample), .in_tile_start(in_ch.tile_start), .last(last_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job));

  evf_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .min_elev(min_r), .last(last_r), .o_valid(out_ch.valid), .o_ready(out_ch.ready),
    .o_res(res));

  assign out_ch.elevation = res.elevation;
  assign out_ch.row = res.row;
  assign out_ch.col = res.col;
  assign out_ch.was_void = res.was_void;
endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import evf_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MIN_ELEV;
  logic [15:0] cfg_data = '0;

  evf_in_if in_if();
  evf_out_if out_if();

  elevation_void_fill dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the block: line stores, window and position counters.
  logic [15:0] fill_row [0:TILE_LAST];
  logic [15:0] raw_row [0:TILE_LAST];
  logic [15:0] win [3][3];
  int row_pos, col_pos;
  int floor_elev = 0;
  int last_ix = TILE_LAST;
  res_t repaired_q[$];

  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_tiles = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_on = 0;
  bit hold_done = 0;
  int hold_cnt = 0;

  function automatic int sx(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic void gather(logic [15:0] nb, int ctr, inout int sum, inout int n);
    if (sx(nb) > ctr) begin
      sum += sx(nb);
      n++;
    end
  endfunction

  function automatic void fill_step(logic [15:0] s, logic ts);
    int r, c, y, x, v, res, sum, n;
    bit vd, up, dn, rt;
    longint avg;
    res_t e;
    if (ts) begin
      row_pos = last_ix;
      col_pos = last_ix;
    end
    r = (row_pos > TILE_LAST) ? TILE_LAST : row_pos;
    c = (col_pos > TILE_LAST) ? TILE_LAST : col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = fill_row[c];
    win[1][2] = raw_row[c];
    win[2][2] = s;
    raw_row[c] = s;
    if (c == 0) fill_row[0] = win[1][2];
    if (r + 1 <= last_ix && c + 1 <= last_ix) begin
      y = r + 1;
      x = c + 1;
      v = sx(win[1][1]);
      res = v;
      vd = v < floor_elev;
      if (vd) begin
        sum = 0;
        n = 0;
        up = y >= 2;
        dn = y + 1 <= last_ix;
        rt = x + 2 <= last_ix;
        if (up) gather(win[2][1], v, sum, n);
        if (dn) gather(win[0][1], v, sum, n);
        if (up && rt) gather(win[2][0], v, sum, n);
        if (rt) gather(win[1][0], v, sum, n);
        if (rt && dn) gather(win[0][0], v, sum, n);
        if (up) gather(win[2][2], v, sum, n);
        gather(win[1][2], v, sum, n);
        if (dn) gather(win[0][2], v, sum, n);
        res = floor_elev;
        if (n != 0) begin
          avg = (longint'(2) * sum + n) / (longint'(2) * n);
          if (avg > floor_elev) res = int'(avg);
        end
        win[1][1] = res[15:0];
      end
      if (x <= TILE_LAST) fill_row[x] = res[15:0];
      e.elevation = res[15:0];
      e.row = y[11:0];
      e.col = x[11:0];
      e.was_void = vd;
      repaired_q.push_back(e);
    end
    if (c == 0) begin
      col_pos = last_ix;
      row_pos = (r == 0) ? last_ix : r - 1;
    end else begin
      col_pos = c - 1;
      row_pos = r;
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) fill_step(in_if.sample, in_if.tile_start);
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (repaired_q.size() == 0) begin
        report("unexpected item row", out_if.row, -1);
      end else begin
        e = repaired_q.pop_front();
        n_checked++;
        if (out_if.elevation !== e.elevation)
          report("elevation", sx(out_if.elevation), sx(e.elevation));
        if (out_if.row !== e.row) report("row", out_if.row, e.row);
        if (out_if.col !== e.col) report("col", out_if.col, e.col);
        if (out_if.was_void !== e.was_void) report("was_void", out_if.was_void, e.was_void);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_on && !hold_done) begin
      hold_cnt++;
      if (hold_cnt >= 400) hold_done = 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_item(logic [15:0] s, logic ts);
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    in_if.tile_start <= ts;
    do @(posedge clk); while (!in_if.ready);
    n_items++;
    if (!quiet && $urandom_range(99) < 21) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (repaired_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_ELEV) floor_elev = sx(data);
    else if (data[11:0] < 2) last_ix = 2;
    else if (data[11:0] > TILE_LAST) last_ix = TILE_LAST;
    else last_ix = data[11:0];
  endtask

  function automatic logic [15:0] pick_sample();
    int v, k;
    k = $urandom_range(99);
    if (k < 20) return 16'($urandom());
    if (k < 55) v = floor_elev - 1 - int'($urandom_range(0, 400));
    else v = floor_elev + int'($urandom_range(0, 3000));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  task automatic send_tile(bit with_start, int count);
    for (int i = 0; i < count; i++) send_item(pick_sample(), with_start && i == 0);
    n_tiles++;
  endtask

  task automatic test_no_start();
    send_item(16'sd5, 1'b0);
    settle();
  endtask

  task automatic test_extremes();
    logic [15:0] vals [9] = '{16'h8000, 16'h7fff, 16'hfffb, 16'h0064, 16'h8000,
                              16'h0001, 16'h7fff, 16'hffff, 16'h8000};
    write_reg(CFG_LAST_IDX, 16'h0000);
    write_reg(CFG_MIN_ELEV, 16'h0000);
    for (int i = 0; i < 9; i++) send_item(vals[i], i == 0);
    for (int i = 0; i < 9; i++) send_item(vals[8 - i], 1'b0);
    write_reg(CFG_MIN_ELEV, 16'h7fff);
    for (int i = 0; i < 9; i++) send_item(vals[i], i == 0);
    write_reg(CFG_LAST_IDX, 16'hffff);
    write_reg(CFG_LAST_IDX, 16'h0003);
    write_reg(CFG_MIN_ELEV, 16'h8000);
    send_tile(1, 16);
    write_reg(CFG_MIN_ELEV, 16'h0000);
    send_tile(1, 16);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_LAST_IDX, 16'd6);
    quiet = 1;
    hold_on = 1;
    send_tile(1, 49);
    send_tile(0, 49);
    quiet = 0;
  endtask

  task automatic test_random();
    int lx, mode;
    bit whole = 0;
    while (n_items < 950) begin
      if ($urandom_range(99) < 40) begin
        mode = $urandom_range(5);
        case (mode)
          0: write_reg(CFG_MIN_ELEV, 16'h8000);
          1: write_reg(CFG_MIN_ELEV, 16'h7fff);
          default: write_reg(CFG_MIN_ELEV, 16'($urandom_range(0, 8000) - 4000));
        endcase
        lx = ($urandom_range(99) < 85) ? $urandom_range(2, 7) : $urandom_range(8, 14);
        write_reg(CFG_LAST_IDX, 16'(lx));
        whole = 0;
      end
      quiet = (n_items > 400 && n_items < 600);
      if ($urandom_range(99) < 10) begin
        send_tile(1, $urandom_range(1, (last_ix + 1) * (last_ix + 1) - 1));
        whole = 0;
      end else begin
        send_tile(!(whole && $urandom_range(99) < 25), (last_ix + 1) * (last_ix + 1));
        whole = 1;
      end
    end
    quiet = 0;
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.sample <= '0;
    in_if.tile_start <= 1'b0;
    for (int i = 0; i <= TILE_LAST; i++) begin
      fill_row[i] = '0;
      raw_row[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_start();
    test_extremes();
    test_backpressure();
    test_random();
    settle();
    repeat (20) @(posedge clk);
    if (repaired_q.size() != 0) report("items still awaited", 0, repaired_q.size());
    $display("Sent %0d samples in %0d tiles; %0d repaired items compared.",
             n_items, n_tiles, n_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
